[rtl/jsu_pkg.sv]
// Package for the JSON string unescaper: beat structs, escape state codes,
// character constants and hex digit helpers. No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int UNIT_W    = 16;
    localparam int MAX_RES   = 5;
    localparam int RES_CNT_W = 3;
    localparam int HELD_N    = 3;
    localparam int HCNT_W    = 2;

    typedef logic [UNIT_W-1:0] t_unit;

    typedef struct packed {
        t_unit in_unit;
        logic  in_last;
    } t_in_beat;

    typedef struct packed {
        t_unit out_unit;
        logic  run_last;
        logic  string_end;
    } t_out_beat;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    localparam t_unit CH_BSLASH = 16'h005C;
    localparam t_unit CH_N      = 16'h006E;
    localparam t_unit CH_T      = 16'h0074;
    localparam t_unit CH_R      = 16'h0072;
    localparam t_unit CH_B      = 16'h0062;
    localparam t_unit CH_F      = 16'h0066;
    localparam t_unit CH_U      = 16'h0075;
    localparam t_unit CTL_LF    = 16'h000A;
    localparam t_unit CTL_TAB   = 16'h0009;
    localparam t_unit CTL_CR    = 16'h000D;
    localparam t_unit CTL_BS    = 16'h0008;
    localparam t_unit CTL_FF    = 16'h000C;

    // ASCII hex digit, either case
    function automatic logic hex_ok(input t_unit u);
        hex_ok = (u >= 16'h0030 && u <= 16'h0039) ||
                 (u >= 16'h0041 && u <= 16'h0046) ||
                 (u >= 16'h0061 && u <= 16'h0066);
    endfunction

    function automatic logic [3:0] hex_val(input t_unit u);
        logic [3:0] v;
        v = u[3:0];
        if (u[6]) begin
            v = u[3:0] + 4'd9;
        end
        hex_val = v;
    endfunction

endpackage

[rtl/json_string_unescape_core.sv]
// JSON string unescaper top level: escape decode, result burst buffer and
// output register. Depends on jsu_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: i_in_valid / o_in_stall / i_in_data, one UTF-16 code unit
//   per beat, in_last marks the unit that ends the string.
//   Output channel: o_out_valid / i_out_stall / o_out_data, one unescaped
//   code unit per beat; run_last flags the last result of an input beat and
//   string_end the final result of the string.
//   An accepted beat is decoded in the same cycle into a burst of zero to
//   five results, held in a burst buffer that feeds the output register one
//   result per cycle while the output is not stalled.
//   Throughput: one input beat per cycle while each beat gives at most one
//   result and the output is not stalled; a beat with more results stalls
//   input until the burst buffer is down to its last result (fallback of a
//   bad hex escape). Beats that give no result (start of an escape) do not
//   load the burst buffer. Input is taken while the output register still
//   holds a stalled result, as long as the burst buffer is empty.
//   Reset (i_rst_n low, synchronous) returns to plain text, drops the burst
//   and the output beat. A stalled output beat holds its payload.
module json_string_unescape_core
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_mode               r_mode, n_mode;
    logic [HCNT_W-1:0]   r_hcnt, n_hcnt;
    t_unit               r_held [HELD_N];

    t_unit               r_bu [MAX_RES];
    logic [RES_CNT_W-1:0] r_bn;
    logic                r_bend;

    logic                r_ov;
    t_out_beat           r_out;

    t_unit               res [MAX_RES];
    logic [RES_CNT_W-1:0] res_n;
    logic                held_wr;
    logic                in_acc;
    logic                move;
    t_unit               unit;
    logic                last;
    logic                is_hex;
    logic [RES_CNT_W-1:0] cnt_ext;

    assign unit    = i_in_data.in_unit;
    assign last    = i_in_data.in_last;
    assign is_hex  = hex_ok(unit);
    assign cnt_ext = RES_CNT_W'(r_hcnt);

    // handshake
    assign move       = (r_bn != '0) && (!r_ov || !i_out_stall);
    assign o_in_stall = !((r_bn == '0) || (r_bn == RES_CNT_W'(1) && move));
    assign in_acc     = i_in_valid && !o_in_stall;

    // decode of one beat against the escape state
    always_comb begin
        n_mode  = r_mode;
        n_hcnt  = r_hcnt;
        held_wr = 1'b0;
        res_n   = '0;
        // fallback layout: 'u', held digits, then the current unit
        res[0] = CH_U;
        for (int k = 1; k <= HELD_N; k++) begin
            if (RES_CNT_W'(k - 1) < cnt_ext) begin
                res[k] = r_held[k-1];
            end else begin
                res[k] = unit;
            end
        end
        res[HELD_N+1] = unit;

        case (r_mode)
            MODE_ESCAPE: begin
                n_mode = MODE_NORMAL;
                res_n  = RES_CNT_W'(1);
                case (unit)
                    CH_N:    res[0] = CTL_LF;
                    CH_T:    res[0] = CTL_TAB;
                    CH_R:    res[0] = CTL_CR;
                    CH_B:    res[0] = CTL_BS;
                    CH_F:    res[0] = CTL_FF;
                    CH_U: begin
                        res[0] = CH_U;
                        if (!last) begin
                            res_n  = '0;
                            n_mode = MODE_HEX;
                            n_hcnt = '0;
                        end
                    end
                    default: res[0] = unit;
                endcase
            end
            MODE_HEX: begin
                if (!is_hex) begin
                    // bad run: flush, then the unit as plain text
                    n_hcnt = '0;
                    n_mode = MODE_NORMAL;
                    if (unit == CH_BSLASH && !last) begin
                        n_mode = MODE_ESCAPE;
                        res_n  = cnt_ext + RES_CNT_W'(1);
                    end else begin
                        res_n  = cnt_ext + RES_CNT_W'(2);
                    end
                end else if (r_hcnt == HCNT_W'(HELD_N)) begin
                    res[0] = {hex_val(r_held[0]), hex_val(r_held[1]),
                              hex_val(r_held[2]), hex_val(unit)};
                    res_n  = RES_CNT_W'(1);
                    n_hcnt = '0;
                    n_mode = MODE_NORMAL;
                end else begin
                    held_wr = 1'b1;
                    n_hcnt  = r_hcnt + HCNT_W'(1);
                    if (last) begin
                        // short run: 'u' plus all digits incl. this one
                        res_n = cnt_ext + RES_CNT_W'(2);
                    end
                end
            end
            default: begin
                n_mode = MODE_NORMAL;
                res[0] = unit;
                if (unit == CH_BSLASH && !last) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    res_n = RES_CNT_W'(1);
                end
            end
        endcase

        if (last) begin
            n_mode = MODE_NORMAL;
            n_hcnt = '0;
        end
    end

    // escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_hcnt <= '0;
        end else if (in_acc) begin
            r_mode <= n_mode;
            r_hcnt <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && held_wr) begin
            r_held[r_hcnt] <= unit;
        end
    end

    // burst buffer, drained from entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bn <= '0;
        end else if (in_acc && res_n != '0) begin
            r_bn <= res_n;
        end else if (move) begin
            r_bn <= r_bn - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_n != '0) begin
            for (int k = 0; k < MAX_RES; k++) begin
                r_bu[k] <= res[k];
            end
            r_bend <= last;
        end else if (move) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_bu[k] <= r_bu[k+1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (move) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out.out_unit   <= r_bu[0];
            r_out.run_last   <= (r_bn == RES_CNT_W'(1));
            r_out.string_end <= (r_bn == RES_CNT_W'(1)) && r_bend;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

[verif/json_string_unescape_core_tb.sv]
// Testbench for json_string_unescape_core: directed and random escaped strings,
// checked beat by beat against an in-bench unescape predictor.
// Depends on jsu_pkg and the json_string_unescape_core RTL.
`timescale 1ns / 1ps

module json_string_unescape_core_tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_data;

    int        in_gap_pct    = 0;
    int        out_stall_pct = 0;
    int        n_fail        = 0;
    int        n_sent        = 0;
    int        n_cycles      = 0;

    // predictor state
    t_mode      esc_mode = MODE_NORMAL;
    logic [1:0] hex_cnt  = '0;
    t_unit      hex_held [HELD_N];
    t_unit      burst [$];

    t_out_beat  pending_units [$];
    t_unit      text [$];

    json_string_unescape_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding", n_cycles,
                   pending_units.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    function automatic int hex_digit(input t_unit u);
        if (u >= 16'h0030 && u <= 16'h0039) return int'(u) - 'h30;
        if (u >= 16'h0041 && u <= 16'h0046) return int'(u) - 'h41 + 10;
        if (u >= 16'h0061 && u <= 16'h0066) return int'(u) - 'h61 + 10;
        return -1;
    endfunction

    // literal u plus whatever digits were collected
    function automatic void flush_hex();
        burst.push_back(CH_U);
        for (int i = 0; i < hex_cnt; i++) begin
            burst.push_back(hex_held[i]);
        end
        hex_cnt  = '0;
        esc_mode = MODE_NORMAL;
    endfunction

    function automatic void plain_unit(input t_unit u, input logic last);
        if (u == CH_BSLASH && !last) begin
            esc_mode = MODE_ESCAPE;
        end else begin
            burst.push_back(u);
        end
    endfunction

    function automatic void unescape_unit(input t_unit u, input logic last);
        int        d;
        int        v;
        t_out_beat b;
        burst.delete();
        d = hex_digit(u);
        case (esc_mode)
            MODE_ESCAPE: begin
                esc_mode = MODE_NORMAL;
                case (u)
                    CH_N: burst.push_back(CTL_LF);
                    CH_T: burst.push_back(CTL_TAB);
                    CH_R: burst.push_back(CTL_CR);
                    CH_B: burst.push_back(CTL_BS);
                    CH_F: burst.push_back(CTL_FF);
                    CH_U: begin
                        if (last) begin
                            burst.push_back(CH_U);
                        end else begin
                            esc_mode = MODE_HEX;
                            hex_cnt  = '0;
                        end
                    end
                    default: burst.push_back(u);
                endcase
            end
            MODE_HEX: begin
                if (d < 0) begin
                    flush_hex();
                    plain_unit(u, last);
                end else if (hex_cnt == 2'd3) begin
                    v = (hex_digit(hex_held[0]) << 12) | (hex_digit(hex_held[1]) << 8) |
                        (hex_digit(hex_held[2]) << 4) | d;
                    burst.push_back(t_unit'(v));
                    hex_cnt  = '0;
                    esc_mode = MODE_NORMAL;
                end else begin
                    hex_held[hex_cnt] = u;
                    hex_cnt = hex_cnt + 2'd1;
                    if (last) begin
                        flush_hex();
                    end
                end
            end
            default: begin
                esc_mode = MODE_NORMAL;
                plain_unit(u, last);
            end
        endcase
        if (last) begin
            esc_mode = MODE_NORMAL;
            hex_cnt  = '0;
        end
        for (int i = 0; i < burst.size(); i++) begin
            b.out_unit   = burst[i];
            b.run_last   = (i == burst.size() - 1);
            b.string_end = (i == burst.size() - 1) && last;
            pending_units.push_back(b);
        end
    endfunction

    // ---------------------------------------------------------------- checker

    // values seen at the falling edge hold through the next rising edge
    always @(negedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_units.size() == 0) begin
                $error("unexpected result beat: out_unit %h", out_data.out_unit);
                n_fail++;
            end else begin
                want = pending_units.pop_front();
                if (out_data.out_unit !== want.out_unit) begin
                    $error("out_unit: expected %h, got %h", want.out_unit, out_data.out_unit);
                    n_fail++;
                end
                if (out_data.run_last !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, out_data.run_last);
                    n_fail++;
                end
                if (out_data.string_end !== want.string_end) begin
                    $error("string_end: expected %b, got %b", want.string_end,
                           out_data.string_end);
                    n_fail++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // one input beat; valid stays high between back-to-back beats
    task automatic push_unit(input t_unit u, input logic last);
        logic taken;
        if ($urandom_range(99) < in_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < in_gap_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_unit: u, in_last: last};
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        unescape_unit(u, last);
        n_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < text.size(); i++) begin
            push_unit(text[i], i == text.size() - 1);
        end
    endtask

    function automatic t_unit rand_hex_digit();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return t_unit'('h30 + r);
        if (r < 16) return t_unit'('h41 + r - 10);
        return t_unit'('h61 + r - 16);
    endfunction

    function automatic t_unit rand_non_hex();
        t_unit u;
        if ($urandom_range(3) == 0) return CH_BSLASH;
        if ($urandom_range(1) == 0) u = t_unit'($urandom_range(16'h0020, 16'h007E));
        else                        u = t_unit'($urandom_range(0, 16'hFFFF));
        while (hex_digit(u) >= 0) u = t_unit'($urandom_range(0, 16'hFFFF));
        return u;
    endfunction

    function automatic void add_segment();
        int    kind;
        t_unit esc_set [8];
        kind    = $urandom_range(99);
        esc_set = '{CH_N, CH_T, CH_R, CH_B, CH_F, 16'h0022, CH_BSLASH, 16'h002F};
        if (kind < 25) begin
            if ($urandom_range(1) == 0) text.push_back(t_unit'($urandom_range(0, 16'hFFFF)));
            else text.push_back(t_unit'($urandom_range(16'h0020, 16'h007E)));
        end else if (kind < 45) begin
            text.push_back(CH_BSLASH);
            if ($urandom_range(3) == 0) text.push_back(t_unit'($urandom_range(0, 16'hFFFF)));
            else text.push_back(esc_set[$urandom_range(0, 7)]);
        end else if (kind < 70) begin
            text.push_back(CH_BSLASH);
            text.push_back(CH_U);
            repeat (4) text.push_back(rand_hex_digit());
        end else if (kind < 85) begin
            // hex run broken by a non-digit
            text.push_back(CH_BSLASH);
            text.push_back(CH_U);
            repeat ($urandom_range(0, 3)) text.push_back(rand_hex_digit());
            text.push_back(rand_non_hex());
        end else begin
            repeat ($urandom_range(1, 3)) text.push_back(t_unit'($urandom_range(0, 16'hFFFF)));
        end
    endfunction

    task automatic test_random_strings(input int n_units);
        int stop_at;
        int seg_start;
        int keep;
        stop_at = n_sent + n_units;
        while (n_sent < stop_at) begin
            text.delete();
            seg_start = 0;
            repeat ($urandom_range(1, 5)) begin
                seg_start = text.size();
                add_segment();
            end
            // cut the string inside its last segment now and then
            if ($urandom_range(3) == 0) begin
                keep = seg_start + $urandom_range(1, text.size() - seg_start);
                while (text.size() > keep) void'(text.pop_back());
            end
            send_string();
        end
    endtask

    task automatic test_plain_extremes();
        text = '{16'h0000, 16'hFFFF};
        send_string();
    endtask

    task automatic test_simple_escapes();
        text = '{CH_BSLASH, CH_N, CH_BSLASH, CH_T, CH_BSLASH, CH_R, CH_BSLASH, CH_B,
                 CH_BSLASH, CH_F, CH_BSLASH, 16'hFFFF};
        send_string();
    endtask

    task automatic test_hex_escapes();
        // good run in mixed case, then three digits cut off by a new escape that
        // ends the string as backslash-u
        text = '{CH_BSLASH, CH_U, 16'h0041, 16'h0062, 16'h0043, 16'h0039,
                 CH_BSLASH, CH_U, 16'h0030, 16'h0066, 16'h0039, CH_BSLASH, CH_U};
        send_string();
    endtask

    task automatic test_string_end_cases();
        text = '{CH_BSLASH, CH_U, 16'h0037};
        send_string();
        text = '{CH_BSLASH};
        send_string();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_gap_pct    = 10;
        out_stall_pct = 10;
        test_plain_extremes();
        test_simple_escapes();
        test_hex_escapes();
        test_string_end_cases();

        test_random_strings(150);
        in_gap_pct    = 0;
        out_stall_pct = 0;
        test_random_strings(100);
        in_gap_pct    = 10;
        out_stall_pct = 10;
        test_random_strings(150);

        in_valid <= 1'b0;
        while (pending_units.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[json_string_unescape_core.f]
rtl/jsu_pkg.sv
rtl/json_string_unescape_core.sv
verif/json_string_unescape_core_tb.sv
